FILE: design/vpts_pkg.sv
// Shared types and constants for the vertex projection pipeline.
`default_nettype none
package vpts_pkg;

    localparam int unsigned NUM_REGS  = 8;
    localparam int unsigned CFG_IDX_W = 4;
    localparam int unsigned CFG_W     = 64;

    // Restoring divider geometry: 48 quotient bits, 32-bit remainder.
    localparam int unsigned DIV_BITS = 48;
    localparam int unsigned REM_W    = 32;
    localparam int unsigned WORD_W   = REM_W + DIV_BITS;
    localparam int unsigned Q_W      = DIV_BITS + 1;

    typedef logic signed [31:0] coef_t;
    typedef coef_t [3:0][3:0] mat_t;
    typedef coef_t [3:0] clip_t;

    typedef struct packed {
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
    } vert_t;

    typedef struct packed {
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic signed [31:0] depth_z;
        logic               w_zero;
    } screen_t;

    // Identity matrix after reset.
    localparam logic [NUM_REGS-1:0][CFG_W-1:0] CFG_RESET = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000
    };

endpackage
`default_nettype wire

FILE: design/vpts_matmul.sv
// Two-stage 4x4 matrix by vertex product giving saturated clip coordinates.
`default_nettype none
module vpts_matmul
    import vpts_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire logic  valid_i,
    input  wire vert_t vert_i,
    input  wire mat_t  mat_i,
    output logic       valid_o,
    output clip_t      clip_o
);

    logic signed [63:0] prod_reg [4][3];
    logic signed [63:0] prod_next [4][3];
    logic               v1_reg;
    logic               v2_reg;
    clip_t              clip_reg;
    clip_t              clip_next;

    // Form the twelve exact products; the w column needs none.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            prod_next[r][0] = mat_i[r][0] * vert_i.vert_x;
            prod_next[r][1] = mat_i[r][1] * vert_i.vert_y;
            prod_next[r][2] = mat_i[r][2] * vert_i.vert_z;
        end
    end

    // Floor each product to Q16.16, sum and saturate.
    always_comb begin
        logic signed [49:0] acc;
        for (int r = 0; r < 4; r++) begin
            acc = 50'(prod_reg[r][0] >>> 16) + 50'(prod_reg[r][1] >>> 16)
                + 50'(prod_reg[r][2] >>> 16) + 50'(mat_i[r][3]);
            if (acc > 50'sd2147483647) begin
                clip_next[r] = 32'sh7FFF_FFFF;
            end else if (acc < -50'sd2147483648) begin
                clip_next[r] = 32'sh8000_0000;
            end else begin
                clip_next[r] = acc[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_i;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            clip_reg <= clip_next;
        end
    end

    assign valid_o = v2_reg;
    assign clip_o  = clip_reg;

endmodule
`default_nettype wire

FILE: design/vpts_div.sv
// Pipelined signed divider lane: one quotient bit per stage, w-zero bypass.
`default_nettype none
module vpts_div
    import vpts_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  en,
    input  wire logic  valid_i,
    input  wire coef_t num_i,
    input  wire coef_t den_i,
    output logic       valid_o,
    output logic       wz_o,
    output logic signed [Q_W-1:0] q_o
);

    logic [WORD_W-1:0] word_reg [DIV_BITS+1];
    logic [WORD_W-1:0] word_next [DIV_BITS];
    logic [REM_W-1:0]  den_reg  [DIV_BITS+1];
    logic              neg_reg  [DIV_BITS+1];
    logic              wz_reg   [DIV_BITS+1];
    coef_t             clip_reg [DIV_BITS+1];
    logic              v_reg    [DIV_BITS+2];
    logic signed [Q_W-1:0] q_reg;
    logic signed [Q_W-1:0] q_next;
    logic [REM_W-1:0]  num_mag;
    logic [REM_W-1:0]  den_mag;

    // Take magnitudes; the dividend is scaled by 2^16.
    assign num_mag = num_i[31] ? REM_W'(-num_i) : REM_W'(num_i);
    assign den_mag = den_i[31] ? REM_W'(-den_i) : REM_W'(den_i);

    // One restoring step per stage.
    for (genvar i = 0; i < DIV_BITS; i++) begin : g_step
        always_comb begin
            logic [WORD_W-1:0] sh;
            sh = word_reg[i] << 1;
            if (sh[WORD_W-1 -: REM_W] >= den_reg[i]) begin
                sh[WORD_W-1 -: REM_W] = sh[WORD_W-1 -: REM_W] - den_reg[i];
                sh[0] = 1'b1;
            end
            word_next[i] = sh;
        end
    end

    // Apply the sign, or pass the clip value when w is zero.
    always_comb begin
        logic signed [Q_W-1:0] uq;
        uq = $signed({1'b0, word_reg[DIV_BITS][DIV_BITS-1:0]});
        if (wz_reg[DIV_BITS]) begin
            q_next = Q_W'(clip_reg[DIV_BITS]);
        end else if (neg_reg[DIV_BITS]) begin
            q_next = -uq;
        end else begin
            q_next = uq;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIV_BITS + 2; i++) v_reg[i] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= valid_i;
            for (int i = 1; i < DIV_BITS + 2; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg[0] <= {{REM_W{1'b0}}, num_mag, 16'h0000};
            den_reg[0]  <= den_mag;
            neg_reg[0]  <= num_i[31] ^ den_i[31];
            wz_reg[0]   <= (den_i == '0);
            clip_reg[0] <= num_i;
            for (int i = 0; i < DIV_BITS; i++) begin
                word_reg[i+1] <= word_next[i];
                den_reg[i+1]  <= den_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                wz_reg[i+1]   <= wz_reg[i];
                clip_reg[i+1] <= clip_reg[i];
            end
            q_reg <= q_next;
        end
    end

    // wz_o lines up with q_o.
    logic wz_out_reg;
    always_ff @(posedge aclk) begin
        if (en) wz_out_reg <= wz_reg[DIV_BITS];
    end

    assign valid_o = v_reg[DIV_BITS+1];
    assign wz_o    = wz_out_reg;
    assign q_o     = q_reg;

endmodule
`default_nettype wire

FILE: design/vpts_screen.sv
// Two-stage viewport mapping and depth saturation into the output register.
`default_nettype none
module vpts_screen
    import vpts_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic en,
    input  wire logic valid_i,
    input  wire logic wz_i,
    input  wire logic signed [Q_W-1:0] qx_i,
    input  wire logic signed [Q_W-1:0] qy_i,
    input  wire logic signed [Q_W-1:0] qz_i,
    output logic      valid_o,
    output screen_t   res_o
);

    localparam logic signed [13:0] SW = 14'(SCREEN_WIDTH);
    localparam logic signed [13:0] SH = 14'(SCREEN_HEIGHT);

    logic signed [63:0] tx_reg, tx_next, ty_reg, ty_next;
    logic signed [31:0] dz_reg, dz_next;
    logic               wz_reg;
    logic               v1_reg, v2_reg;
    screen_t            res_reg, res_next;

    function automatic logic signed [15:0] trunc_sat(input logic signed [63:0] t);
        logic signed [63:0] b;
        logic signed [46:0] s;
        b = t[63] ? t + 64'sd131071 : t;
        s = 47'(b >>> 17);
        if (s > 47'sd32767) return 16'sh7FFF;
        else if (s < -47'sd32768) return 16'sh8000;
        else return s[15:0];
    endfunction

    // Scale (1 - q) by the screen size; saturate depth.
    always_comb begin
        logic signed [49:0] dx, dy;
        dx = 50'sd65536 - 50'(qx_i);
        dy = 50'sd65536 - 50'(qy_i);
        tx_next = dx * SW;
        ty_next = dy * SH;
        if (qz_i > 49'sd2147483647) dz_next = 32'sh7FFF_FFFF;
        else if (qz_i < -49'sd2147483648) dz_next = 32'sh8000_0000;
        else dz_next = qz_i[31:0];
    end

    // Halve with truncation toward zero and clamp to 16 bits.
    always_comb begin
        res_next.screen_x = trunc_sat(tx_reg);
        res_next.screen_y = trunc_sat(ty_reg);
        res_next.depth_z  = dz_reg;
        res_next.w_zero   = wz_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= valid_i;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            tx_reg  <= tx_next;
            ty_reg  <= ty_next;
            dz_reg  <= dz_next;
            wz_reg  <= wz_i;
            res_reg <= res_next;
        end
    end

    assign valid_o = v2_reg;
    assign res_o   = res_reg;

endmodule
`default_nettype wire

FILE: design/vertex_project_to_screen_top.sv
// Top level: configuration registers, projection pipeline and handshake.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data  (vert_t)
//  m_      | out       | m_valid / m_ready  | m_data  (screen_t)
//  cfg_    | in        | cfg_we             | cfg_index, cfg_data
//
// One vertex per cycle enters while no stall holds the pipeline; it passes the
// matrix product, the 48-stage restoring divider lanes and viewport mapping.
// The whole pipeline advances together whenever the output register is empty
// or taken; a stall freezes every stage, so nothing is lost or repeated.
// Synchronous active-low reset clears the valid bits and restores the
// identity matrix.
`default_nettype none
module vertex_project_to_screen_top
    import vpts_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 640,
    parameter int SCREEN_HEIGHT = 480
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire vert_t                s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output screen_t                   m_data,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic [NUM_REGS-1:0][CFG_W-1:0] cfg_reg;
    mat_t  mat;
    logic  en;
    logic  mm_valid;
    clip_t clip;
    logic  xv, yv, zv, xwz, ywz, zwz;
    logic signed [Q_W-1:0] qx, qy, qz;

    // Hold the matrix registers; ignore indexes past the list.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
            cfg_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Unpack half-rows into coefficients.
    always_comb begin
        for (int r = 0; r < 4; r++) begin
            mat[r][0] = cfg_reg[2*r][63:32];
            mat[r][1] = cfg_reg[2*r][31:0];
            mat[r][2] = cfg_reg[2*r+1][63:32];
            mat[r][3] = cfg_reg[2*r+1][31:0];
        end
    end

    // Advance all stages when the output register can take a transaction.
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    vpts_matmul u_matmul (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(s_valid && s_ready),
        .vert_i(s_data), .mat_i(mat), .valid_o(mm_valid), .clip_o(clip)
    );

    vpts_div u_div_x (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(mm_valid),
        .num_i(clip[0]), .den_i(clip[3]), .valid_o(xv), .wz_o(xwz), .q_o(qx)
    );

    vpts_div u_div_y (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(mm_valid),
        .num_i(clip[1]), .den_i(clip[3]), .valid_o(yv), .wz_o(ywz), .q_o(qy)
    );

    vpts_div u_div_z (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(mm_valid),
        .num_i(clip[2]), .den_i(clip[3]), .valid_o(zv), .wz_o(zwz), .q_o(qz)
    );

    vpts_screen #(
        .SCREEN_WIDTH(SCREEN_WIDTH), .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_screen (
        .aclk(aclk), .aresetn(aresetn), .en(en), .valid_i(xv), .wz_i(xwz),
        .qx_i(qx), .qy_i(qy), .qz_i(qz), .valid_o(m_valid), .res_o(m_data)
    );

    // Lanes share one divisor, so their valid and zero flags must agree.
    a_lane_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (xv == yv) && (xv == zv))
        else $error("divider lanes out of step");

    a_lane_wz: assert property (@(posedge aclk) disable iff (!aresetn)
        xv |-> ((xwz == ywz) && (xwz == zwz)))
        else $error("divider lanes disagree on zero w");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

endmodule
`default_nettype wire
